### rtl/ptq_pkg.sv
// ptq_pkg: request and response transfer types, slot entry layout and codes
// for the periodic timer queue. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ptq_pkg;

    localparam int TIMER_SLOTS_DEF = 16;

    // request codes
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;

    // result codes
    localparam logic [2:0] KIND_ADDED     = 3'd0;
    localparam logic [2:0] KIND_FULL      = 3'd1;
    localparam logic [2:0] KIND_REMOVED   = 3'd2;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
    localparam logic [2:0] KIND_FIRED     = 3'd4;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [23:0] delay_ticks;
        logic [23:0] period_ticks;
        logic [31:0] target_id;
    } t_req;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [31:0] timer_ident;
        logic        last;
    } t_rsp;

    // one timer table entry as held in the slot ram
    typedef struct packed {
        logic [31:0] ident;
        logic [31:0] expiry;
        logic [23:0] period;
    } t_slot;

endpackage

`default_nettype wire

### rtl/ptq_ram.sv
// ptq_ram: generic single write port, single read port ram with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ptq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/periodic_timer_queue_unit.sv
// periodic_timer_queue_unit: table of software timers with add, remove and tick
// requests, run by a small sequencer around one shared 32-bit adder.
// Depends on ptq_pkg and ptq_ram.
//
//   Requests arrive as t_req transfers on i_in_valid / o_in_stall, responses leave
//   as t_rsp transfers on o_out_valid / i_out_stall; the last response caused by a
//   request has last set, and a request of type three is taken and gives none.
//   o_in_stall is high while a request is worked on, at least until its last response sits
//   in the output register; the next request may be taken while that one waits.
//   Slots live in a ram with one read port and a registered read, so each pass over
//   the N = TIMER_SLOTS entries reads them one address at a time. What each request does:
//   add:    search for the lowest free slot, refused when none is free.
//   remove: one pass comparing identifiers.
//   tick:   time increment, expiry pass and one selection pass; then each fired
//           timer is sent and, if periodic, reloaded, and a selection pass comes
//           before each further timer, picked as the lowest identifier.
//   Reset clears the valid bits, the time counter and the identifier counter;
//   the ram is not cleared, entries are read only behind a set valid bit.
//   When the receiver stalls, the response holds in the output register and
//   the sequencer waits before producing the next one.
`timescale 1ns / 1ps
`default_nettype none

module periodic_timer_queue_unit
    import ptq_pkg::*;
#(
    parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_req i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_rsp      o_out_data
);

    localparam int IW = $clog2(TIMER_SLOTS);
    localparam logic [IW-1:0] LAST = IW'(TIMER_SLOTS - 1);
    localparam int SW = $bits(t_slot);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_SCAN,
        S_ADD_PUT,
        S_ADD_INC,
        S_ADD_FULL,
        S_RM_SCAN,
        S_RM_DONE,
        S_TICK_INC,
        S_TICK_PEND,
        S_TICK_SEL,
        S_TICK_FIRE,
        S_TICK_RELOAD
    } t_state;

    t_state               r_state, n_state;
    t_req                 r_req, n_req;
    logic [IW-1:0]        r_idx, n_idx;
    logic [IW-1:0]        r_pidx, n_pidx;
    logic                 r_pvld, n_pvld;
    logic                 r_issue_done, n_issue_done;
    logic [TIMER_SLOTS-1:0] r_valid, n_valid;
    logic [TIMER_SLOTS-1:0] r_pending, n_pending;
    logic [31:0]          r_time, n_time;
    logic [31:0]          r_next_id, n_next_id;
    logic                 r_found, n_found;
    logic                 r_best_vld, n_best_vld;
    logic [IW-1:0]        r_best_idx, n_best_idx;
    t_slot                r_best, n_best;
    logic                 r_out_valid, n_out_valid;
    t_rsp                 r_out, n_out;

    // slot ram
    logic                 ram_we;
    logic [IW-1:0]        ram_waddr;
    t_slot                ram_wdata;
    logic [SW-1:0]        ram_rdata;
    t_slot                rd_slot;

    // shared adder
    logic [31:0]          add_a, add_b, add_sum;
    logic                 add_cin;

    logic                 out_free;
    logic                 scan_last;
    logic [23:0]          delay_eff;
    logic [TIMER_SLOTS-1:0] best_mask;
    logic [TIMER_SLOTS-1:0] rest_pending;

    ptq_ram #(
        .WIDTH (SW),
        .DEPTH (TIMER_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_slot      = t_slot'(ram_rdata);
    assign add_sum      = add_a + add_b + {31'd0, add_cin};
    assign out_free     = !r_out_valid || !i_out_stall;
    assign scan_last    = r_pvld && (r_pidx == LAST);
    assign delay_eff    = (r_req.delay_ticks == 24'd0) ? 24'd1 : r_req.delay_ticks;
    assign best_mask    = TIMER_SLOTS'(1) << r_best_idx;
    assign rest_pending = r_pending & ~best_mask;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_idx        = r_idx;
        n_pidx       = r_pidx;
        n_pvld       = r_pvld;
        n_issue_done = r_issue_done;
        n_valid      = r_valid;
        n_pending    = r_pending;
        n_time       = r_time;
        n_next_id    = r_next_id;
        n_found      = r_found;
        n_best_vld   = r_best_vld;
        n_best_idx   = r_best_idx;
        n_best       = r_best;
        n_out_valid  = r_out_valid;
        n_out        = r_out;

        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = r_best;

        add_a   = r_time;
        add_b   = 32'd0;
        add_cin = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // ram pass: issue one address a cycle, handle its data in the following cycle
        if (r_state == S_RM_SCAN || r_state == S_TICK_PEND || r_state == S_TICK_SEL) begin
            n_pidx = r_idx;
            n_pvld = !r_issue_done;
            if (!r_issue_done) begin
                if (r_idx == LAST) begin
                    n_issue_done = 1'b1;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req        = i_in_data;
                    n_idx        = '0;
                    n_pvld       = 1'b0;
                    n_issue_done = 1'b0;
                    n_found      = 1'b0;
                    n_best_vld   = 1'b0;
                    unique case (i_in_data.req_type)
                        REQ_ADD:    n_state = S_ADD_SCAN;
                        REQ_REMOVE: n_state = S_RM_SCAN;
                        REQ_TICK: begin
                            n_pending = '0;
                            n_state   = S_TICK_INC;
                        end
                        default:    n_state = S_IDLE;
                    endcase
                end
            end

            S_ADD_SCAN: begin
                if (!r_valid[r_idx]) begin
                    n_state = S_ADD_PUT;
                end else if (r_idx == LAST) begin
                    n_state = S_ADD_FULL;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end

            S_ADD_PUT: begin
                add_a = r_time;
                add_b = {8'd0, delay_eff};
                if (out_free) begin
                    ram_we           = 1'b1;
                    ram_waddr        = r_idx;
                    ram_wdata.ident  = r_next_id;
                    ram_wdata.expiry = add_sum;
                    ram_wdata.period = r_req.period_ticks;
                    n_valid[r_idx]   = 1'b1;
                    n_out_valid      = 1'b1;
                    n_out.result_kind = KIND_ADDED;
                    n_out.timer_ident = r_next_id;
                    n_out.last        = 1'b1;
                    n_state           = S_ADD_INC;
                end
            end

            S_ADD_INC: begin
                add_a     = r_next_id;
                add_cin   = 1'b1;
                n_next_id = add_sum;
                n_state   = S_IDLE;
            end

            S_ADD_FULL: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.result_kind = KIND_FULL;
                    n_out.timer_ident = 32'd0;
                    n_out.last        = 1'b1;
                    n_state           = S_IDLE;
                end
            end

            S_RM_SCAN: begin
                // every matching slot is freed, one response for all of them
                if (r_pvld && r_valid[r_pidx] && (rd_slot.ident == r_req.target_id)) begin
                    n_valid[r_pidx] = 1'b0;
                    n_found         = 1'b1;
                end
                if (scan_last) begin
                    n_state = S_RM_DONE;
                end
            end

            S_RM_DONE: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.result_kind = r_found ? KIND_REMOVED : KIND_NOT_FOUND;
                    n_out.timer_ident = r_req.target_id;
                    n_out.last        = 1'b1;
                    n_state           = S_IDLE;
                end
            end

            S_TICK_INC: begin
                add_a   = r_time;
                add_cin = 1'b1;
                n_time  = add_sum;
                n_state = S_TICK_PEND;
            end

            S_TICK_PEND: begin
                // wrap-safe expiry test: time minus expiry below half range
                add_a   = r_time;
                add_b   = ~rd_slot.expiry;
                add_cin = 1'b1;
                if (r_pvld) begin
                    n_pending[r_pidx] = r_valid[r_pidx] && !add_sum[31];
                end
                if (scan_last) begin
                    n_idx        = '0;
                    n_pvld       = 1'b0;
                    n_issue_done = 1'b0;
                    n_best_vld   = 1'b0;
                    n_state      = S_TICK_SEL;
                end
            end

            S_TICK_SEL: begin
                // strict less keeps the lowest slot on equal identifiers
                if (r_pvld && r_pending[r_pidx]
                        && (!r_best_vld || (rd_slot.ident < r_best.ident))) begin
                    n_best_vld = 1'b1;
                    n_best_idx = r_pidx;
                    n_best     = rd_slot;
                end
                if (scan_last) begin
                    n_state = n_best_vld ? S_TICK_FIRE : S_IDLE;
                end
            end

            S_TICK_FIRE: begin
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_out.result_kind     = KIND_FIRED;
                    n_out.timer_ident     = r_best.ident;
                    n_out.last            = (rest_pending == '0);
                    n_pending[r_best_idx] = 1'b0;
                    n_idx                 = '0;
                    n_pvld                = 1'b0;
                    n_issue_done          = 1'b0;
                    n_best_vld            = 1'b0;
                    if (r_best.period != 24'd0) begin
                        n_state = S_TICK_RELOAD;
                    end else begin
                        n_valid[r_best_idx] = 1'b0;
                        n_state = (rest_pending == '0) ? S_IDLE : S_TICK_SEL;
                    end
                end
            end

            S_TICK_RELOAD: begin
                add_a            = r_best.expiry;
                add_b            = {8'd0, r_best.period};
                ram_we           = 1'b1;
                ram_waddr        = r_best_idx;
                ram_wdata.ident  = r_best.ident;
                ram_wdata.expiry = add_sum;
                ram_wdata.period = r_best.period;
                n_state          = (r_pending == '0) ? S_IDLE : S_TICK_SEL;
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pvld       <= 1'b0;
            r_issue_done <= 1'b0;
            r_valid      <= '0;
            r_pending    <= '0;
            r_time       <= 32'd0;
            r_next_id    <= 32'd0;
            r_found      <= 1'b0;
            r_best_vld   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pvld       <= n_pvld;
            r_issue_done <= n_issue_done;
            r_valid      <= n_valid;
            r_pending    <= n_pending;
            r_time       <= n_time;
            r_next_id    <= n_next_id;
            r_found      <= n_found;
            r_best_vld   <= n_best_vld;
            r_out_valid  <= n_out_valid;
        end
        r_req      <= n_req;
        r_idx      <= n_idx;
        r_pidx     <= n_pidx;
        r_best_idx <= n_best_idx;
        r_best     <= n_best;
        r_out      <= n_out;
    end

endmodule

`default_nettype wire

### sim/periodic_timer_queue_unit_test.sv
// periodic_timer_queue_unit_test: self-checking bench for the timer table, with a
// scoreboard class that predicts every response from the accepted requests.
// Depends on ptq_pkg and periodic_timer_queue_unit.
`timescale 1ns / 1ps

import ptq_pkg::*;

class timer_scoreboard;
    bit          live[TIMER_SLOTS_DEF];
    logic [31:0] ident[TIMER_SLOTS_DEF];
    logic [31:0] due[TIMER_SLOTS_DEF];
    logic [23:0] reload[TIMER_SLOTS_DEF];
    logic [31:0] now_tick;
    logic [31:0] next_id;
    t_rsp        awaited_rsp[$];
    int          mismatches;
    int          n_added, n_full, n_removed, n_missing, n_fired, most_fired;

    function new();
        foreach (live[s]) live[s] = 1'b0;
        now_tick   = '0;
        next_id    = '0;
        mismatches = 0;
        n_added    = 0;
        n_full     = 0;
        n_removed  = 0;
        n_missing  = 0;
        n_fired    = 0;
        most_fired = 0;
    endfunction

    function void await_rsp(logic [2:0] kind, logic [31:0] id, logic last);
        t_rsp r;
        r.result_kind = kind;
        r.timer_ident = id;
        r.last        = last;
        awaited_rsp.push_back(r);
    endfunction

    // work out the responses that one accepted request must produce
    function void note_request(t_req r);
        int          free_slot;
        int          best;
        int          total;
        bit          found;
        bit          ripe[TIMER_SLOTS_DEF];
        logic [31:0] delay;
        logic [31:0] elapsed;
        case (r.req_type)
            REQ_ADD: begin
                free_slot = -1;
                for (int s = 0; s < TIMER_SLOTS_DEF; s++)
                    if (!live[s] && free_slot < 0) free_slot = s;
                if (free_slot < 0) begin
                    await_rsp(KIND_FULL, 32'd0, 1'b1);
                    n_full++;
                end else begin
                    delay = (r.delay_ticks == 24'd0) ? 32'd1 : {8'd0, r.delay_ticks};
                    live[free_slot]   = 1'b1;
                    ident[free_slot]  = next_id;
                    due[free_slot]    = now_tick + delay;
                    reload[free_slot] = r.period_ticks;
                    await_rsp(KIND_ADDED, next_id, 1'b1);
                    next_id = next_id + 32'd1;
                    n_added++;
                end
            end
            REQ_REMOVE: begin
                found = 1'b0;
                for (int s = 0; s < TIMER_SLOTS_DEF; s++) begin
                    if (live[s] && ident[s] == r.target_id) begin
                        live[s] = 1'b0;
                        found   = 1'b1;
                    end
                end
                if (found) n_removed++;
                else n_missing++;
                await_rsp(found ? KIND_REMOVED : KIND_NOT_FOUND, r.target_id, 1'b1);
            end
            REQ_TICK: begin
                now_tick = now_tick + 32'd1;
                total = 0;
                for (int s = 0; s < TIMER_SLOTS_DEF; s++) begin
                    // wrap-safe: expired once now has reached the due time
                    elapsed = now_tick - due[s];
                    ripe[s] = live[s] && (elapsed < 32'h8000_0000);
                    if (ripe[s]) total++;
                end
                for (int k = 0; k < total; k++) begin
                    best = -1;
                    for (int s = 0; s < TIMER_SLOTS_DEF; s++)
                        if (ripe[s] && (best < 0 || ident[s] < ident[best])) best = s;
                    ripe[best] = 1'b0;
                    await_rsp(KIND_FIRED, ident[best], k == total - 1);
                    if (reload[best] != 24'd0) due[best] = due[best] + {8'd0, reload[best]};
                    else live[best] = 1'b0;
                end
                n_fired += total;
                if (total > most_fired) most_fired = total;
            end
            default: ;
        endcase
    endfunction

    function void check_response(t_rsp got);
        t_rsp want;
        if (awaited_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected response at %0t: kind %0d id %h last %0b",
                         $time, got.result_kind, got.timer_ident, got.last);
        end else begin
            want = awaited_rsp.pop_front();
            if (got.result_kind !== want.result_kind || got.timer_ident !== want.timer_ident ||
                got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch at %0t: expected %0d/%h/%0b, got %0d/%h/%0b",
                             $time, want.result_kind, want.timer_ident, want.last,
                             got.result_kind, got.timer_ident, got.last);
            end
        end
    endfunction
endclass

module periodic_timer_queue_unit_test;

    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam int RANDOM_PER_PHASE = 123;
    localparam int RX_HOLD_CYCLES   = 300;

    logic i_clk     = 1'b0;
    logic i_rst_n   = 1'b0;
    logic req_valid = 1'b0;
    t_req req_data  = '0;
    logic rsp_stall = 1'b0;
    logic req_stall;
    logic rsp_valid;
    t_rsp rsp_data;

    int tx_gap_pct   = 0;
    int rx_stall_pct = 0;
    bit rx_hold_req  = 1'b0;

    timer_scoreboard sb = new();

    periodic_timer_queue_unit #(
        .TIMER_SLOTS(TIMER_SLOTS_DEF)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (req_valid),
        .o_in_stall (req_stall),
        .i_in_data  (req_data),
        .o_out_valid(rsp_valid),
        .i_out_stall(rsp_stall),
        .o_out_data (rsp_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // check before noting, so a response never meets the request of the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
            if (req_valid && !req_stall) sb.note_request(req_data);
        end
    end

    // receiver: random stalls, or one long hold-off counted here
    initial begin : receiver
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                rsp_stall <= 1'b1;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
            end else begin
                rsp_stall <= ($urandom_range(99) < rx_stall_pct);
            end
        end
    end

    initial begin : watchdog
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic t_req make_req(logic [1:0] kind, logic [23:0] delay,
                                      logic [23:0] period, logic [31:0] target);
        t_req r;
        r.req_type     = kind;
        r.delay_ticks  = delay;
        r.period_ticks = period;
        r.target_id    = target;
        return r;
    endfunction

    // mostly short timers so that ticks fire often; unused fields carry noise
    function automatic t_req random_request();
        t_req r;
        int   pick;
        int   live_idx[$];
        r.req_type     = REQ_TICK;
        r.delay_ticks  = 24'($urandom());
        r.period_ticks = 24'($urandom());
        r.target_id    = $urandom();
        pick = $urandom_range(99);
        if (pick < 4) begin
            r.req_type = REQ_NONE;
        end else if (pick < 44) begin
            r.req_type = REQ_ADD;
            pick = $urandom_range(9);
            if (pick < 7) r.delay_ticks = 24'($urandom_range(6));
            else if (pick < 9) r.delay_ticks = 24'($urandom_range(64));
            pick = $urandom_range(19);
            if (pick < 8) r.period_ticks = 24'd0;
            else if (pick < 17) r.period_ticks = 24'($urandom_range(8, 1));
        end else if (pick < 60) begin
            r.req_type = REQ_REMOVE;
            for (int s = 0; s < TIMER_SLOTS_DEF; s++)
                if (sb.live[s]) live_idx.push_back(s);
            pick = $urandom_range(9);
            if (pick < 7 && live_idx.size() > 0)
                r.target_id = sb.ident[live_idx[$urandom_range(live_idx.size() - 1)]];
            else if (pick < 9)
                r.target_id = sb.next_id - 32'd1 - 32'($urandom_range(3));
        end
        return r;
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_request(input t_req r);
        while ($urandom_range(99) < tx_gap_pct) begin
            req_valid <= 1'b0;
            @(negedge i_clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge i_clk);
        while (req_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic pause_until_drained();
        req_valid <= 1'b0;
        while (sb.awaited_rsp.size() != 0) @(negedge i_clk);
        repeat (2 * TIMER_SLOTS_DEF + 8) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int   sent;
        int   waited;
        t_req r;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_request(make_req(REQ_TICK, 24'd0, 24'd0, 32'd0));
        send_request(make_req(REQ_REMOVE, 24'd0, 24'd0, 32'hFFFF_FFFF));
        send_request(make_req(REQ_ADD, 24'd0, 24'd0, 32'd0));
        send_request(make_req(REQ_TICK, 24'd0, 24'd0, 32'd0));
        // later id in a lower slot, so firing order differs from slot order
        send_request(make_req(REQ_ADD, 24'd2, 24'd1, 32'd0));
        send_request(make_req(REQ_ADD, 24'd1, 24'd0, 32'd0));
        send_request(make_req(REQ_REMOVE, 24'd0, 24'd0, 32'd1));
        send_request(make_req(REQ_ADD, 24'd1, 24'd3, 32'd0));
        send_request(make_req(REQ_TICK, 24'd0, 24'd0, 32'd0));
        send_request(make_req(REQ_ADD, 24'hFF_FFFF, 24'hFF_FFFF, 32'd0));
        // fill the table, the last add is refused
        for (int k = 0; k < 15; k++)
            send_request(make_req(REQ_ADD, 24'(k % 3), (k % 2) ? 24'd1 : 24'd0, 32'd0));
        send_request(make_req(REQ_TICK, 24'd0, 24'd0, 32'd0));
        pause_until_drained();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    tx_gap_pct   = 11;
                    rx_stall_pct = 74;
                end
                1: begin
                    tx_gap_pct   = 74;
                    rx_stall_pct = 11;
                end
                default: begin
                    tx_gap_pct   = 0;
                    rx_stall_pct = 0;
                    rx_hold_req  = 1'b1;
                end
            endcase
            sent = 0;
            while (sent < RANDOM_PER_PHASE) begin
                r = random_request();
                send_request(r);
                if (r.req_type != REQ_NONE) sent++;
            end
            pause_until_drained();
        end

        waited = 0;
        while (sb.awaited_rsp.size() != 0 && waited < 50000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (40) @(negedge i_clk);
        if (sb.awaited_rsp.size() != 0) begin
            $display("%0d responses never arrived", sb.awaited_rsp.size());
            sb.mismatches += sb.awaited_rsp.size();
        end

        $display("run covered %0d adds (%0d refused on a full table), %0d removes hit, %0d missed",
                 sb.n_added, sb.n_full, sb.n_removed, sb.n_missing);
        $display("%0d timer firings over %0d ticks, at most %0d in one tick; %0d mismatches",
                 sb.n_fired, sb.now_tick, sb.most_fired, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
